@@ src/prr_pkg.sv @@
// Shared widths, codes and saturation limits of the polyphase rational resampler.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package prr_pkg;

    // Field widths of the request and result items
    localparam int REQ_W      = 2;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int SHIFT_W    = 6;
    localparam int PHSEL_W    = 2;
    localparam int TAPSEL_W   = 5;

    // Configuration registers
    localparam int INTERP_W   = 3;
    localparam int DECIM_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = 1'b1;

    // Result limits and rounding
    localparam int RESULT_CAP = 40;
    localparam int ROUND_HALF = 32768;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE     = 2'd0,
        REQ_END        = 2'd1,
        REQ_LOAD_COEF  = 2'd2,
        REQ_LOAD_SHIFT = 2'd3
    } t_req;

endpackage

@@ src/prr_in_if.sv @@
// Request channel of the resampler: valid/ready plus the request item fields.
// Depends on prr_pkg for the field widths.
`timescale 1ns / 1ps

interface prr_in_if;

    logic                                 valid;
    logic                                 ready;
    logic        [prr_pkg::REQ_W-1:0]     req_type;
    logic signed [prr_pkg::SAMPLE_W-1:0]  sample_re;
    logic signed [prr_pkg::SAMPLE_W-1:0]  sample_im;
    logic        [prr_pkg::PHSEL_W-1:0]   phase_sel;
    logic        [prr_pkg::TAPSEL_W-1:0]  tap_sel;
    logic signed [prr_pkg::COEF_W-1:0]    load_value;

    modport source (
        output valid, req_type, sample_re, sample_im, phase_sel, tap_sel, load_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, sample_re, sample_im, phase_sel, tap_sel, load_value,
        output ready
    );

endinterface

@@ src/prr_out_if.sv @@
// Result channel of the resampler: valid/ready plus the result item fields.
// Depends on prr_pkg for the field widths.
`timescale 1ns / 1ps

interface prr_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [prr_pkg::SAMPLE_W-1:0] out_re;
    logic signed [prr_pkg::SAMPLE_W-1:0] out_im;
    logic                                last;

    modport source (
        output valid, out_re, out_im, last,
        input  ready
    );

    modport sink (
        input  valid, out_re, out_im, last,
        output ready
    );

endinterface

@@ src/polyphase_rational_resampler_top.sv @@
// Top level of the polyphase rational resampler (L/M, complex Q1.15 stream).
// Depends on prr_pkg, prr_in_if and prr_out_if.
//
// Usage:
//  - i_req carries items: a sample, an end of stream, a coefficient load
//    (phase_sel, tap_sel, load_value) or a phase shift load (phase_sel,
//    low 6 bits of load_value). o_res carries filter outputs; last marks the
//    final result caused by one request item.
//  - i_cfg_we/i_cfg_idx/i_cfg_data write L (index 0) and M (index 1); write
//    them only while the block is idle.
//  - Loads return nothing. A sample or end item holds
//    i_req.ready low until all its results are computed. Each result runs
//    FILTER_ORDER+1 taps through the one complex MAC (two 16x18 multipliers,
//    one tap per cycle) after an address step and a window check, then
//    drains the pipeline and hands off to the output register; an end item
//    first pushes FILTER_ORDER/2 trailing zeros.
//  - Results go through a one-entry output register: a stalled receiver only
//    holds the sequencer when the next result is ready and the register is full.
//  - Synchronous reset (i_rst_n low) empties the history (valid bits cleared
//    at once), rewinds the stream and sets L = M = 1. Coefficient and shift
//    tables are not cleared and must be loaded before use.
`timescale 1ns / 1ps

module polyphase_rational_resampler_top #(
    parameter int MAX_PHASES    = 4,
    parameter int FILTER_ORDER  = 16,
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    prr_in_if.sink                             i_req,
    prr_out_if.source                          o_res,
    input  logic                               i_cfg_we,
    input  logic [prr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [prr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int TAPS    = FILTER_ORDER + 1;
    localparam int HALF    = FILTER_ORDER / 2;
    localparam int PW      = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
    localparam int SW      = $clog2(HISTORY_DEPTH);
    localparam int CW      = $clog2(MAX_PHASES * TAPS);
    localparam int TW      = $clog2(TAPS);
    localparam int ZW      = $clog2(HALF + 1);
    localparam int NW      = $clog2(prr_pkg::RESULT_CAP + 1);
    localparam int PROD_W  = prr_pkg::SAMPLE_W + prr_pkg::COEF_W;
    localparam int AW      = PROD_W + $clog2(TAPS);
    localparam int HW      = 2 * prr_pkg::SAMPLE_W;

    localparam logic signed [SW+1:0] DEPTH_S = (SW + 2)'(HISTORY_DEPTH);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PUSH  = 7'b0000010,
        S_ADDR  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_MAC   = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state                             r_state, n_state;
    logic [prr_pkg::INTERP_W-1:0]       r_interp;
    logic [prr_pkg::DECIM_W-1:0]        r_decim;

    logic [HW-1:0]                      r_hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]           r_hvalid;
    logic signed [prr_pkg::COEF_W-1:0]  r_coef_mem [MAX_PHASES * TAPS];
    logic signed [prr_pkg::SHIFT_W-1:0] r_shift    [MAX_PHASES];

    logic [31:0]                        r_seen;
    logic [SW-1:0]                      r_wr_slot;
    logic [31:0]                        r_base;
    logic [SW-1:0]                      r_base_slot;
    logic [PW-1:0]                      r_phase;
    logic [NW-1:0]                      r_nres;
    logic                               r_is_end;
    logic [ZW-1:0]                      r_zcnt;
    logic                               r_more;
    logic [TW-1:0]                      r_tap;

    logic [31:0]                        r_start;
    logic [SW-1:0]                      r_rd_slot;
    logic [CW-1:0]                      r_coef_addr;

    // MAC pipeline: read -> multiply -> accumulate
    logic                               r_s1, r_s2;
    logic [HW-1:0]                      r_hist_q;
    logic                               r_hist_v;
    logic signed [prr_pkg::COEF_W-1:0]  r_coef_q;
    logic signed [PROD_W-1:0]           r_prod_re, r_prod_im;
    logic signed [AW-1:0]               r_acc_re, r_acc_im;

    logic                               r_pend_vld;
    logic signed [prr_pkg::SAMPLE_W-1:0] r_pend_re, r_pend_im;
    logic                               r_out_valid;
    logic signed [prr_pkg::SAMPLE_W-1:0] r_out_re, r_out_im;
    logic                               r_out_last;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // Bring a slot sum back into [0, HISTORY_DEPTH); input is within one depth.
    function automatic logic [SW-1:0] wrap_slot(input logic signed [SW+1:0] v);
        logic [SW-1:0] res;
        if (v < 0) begin
            res = SW'(v + DEPTH_S);
        end else if (v >= DEPTH_S) begin
            res = SW'(v - DEPTH_S);
        end else begin
            res = SW'(v);
        end
        return res;
    endfunction

    // Round half up to Q1.15, then saturate.
    function automatic logic signed [prr_pkg::SAMPLE_W-1:0] round_sat(
        input logic signed [AW-1:0] acc
    );
        logic signed [AW:0]               sum;
        logic [AW-16:0]                   q;
        logic signed [prr_pkg::SAMPLE_W-1:0] res;
        sum = (AW + 1)'(acc) + (AW + 1)'(prr_pkg::ROUND_HALF);
        q   = sum[AW:16];
        if ((&q[AW-16:15]) || (~|q[AW-16:15])) begin
            res = q[15:0];
        end else if (q[AW-16]) begin
            res = prr_pkg::SAT_MIN;
        end else begin
            res = prr_pkg::SAT_MAX;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Combinational control
    // ------------------------------------------------------------------
    prr_pkg::t_req          req_kind;
    logic                   req_acc;
    logic                   hist_we, coef_we, shift_we;
    logic                   ph_ok, tap_ok;
    logic [CW-1:0]          coef_waddr, coef_base;
    logic [3:0]             l_eff;
    logic [prr_pkg::DECIM_W-1:0] m_eff;
    logic signed [prr_pkg::SHIFT_W-1:0] cur_shift;
    logic [SW-1:0]          start_slot, wr_slot_inc, rd_slot_inc, base_slot_nxt;
    logic [31:0]            ahead;
    logic                   win_ok, more;
    logic                   out_free, pipe_idle, mac_last;
    logic [3:0]             phase_inc;
    logic                   ph_wrap;
    logic signed [6:0]      delta;
    logic                   res_done, emit_load, finish;
    logic signed [prr_pkg::SAMPLE_W-1:0] h_re, h_im;

    assign req_acc  = i_req.valid && i_req.ready;
    assign req_kind = prr_pkg::t_req'(i_req.req_type);
    assign ph_ok    = 32'(i_req.phase_sel) < MAX_PHASES;
    assign tap_ok   = 32'(i_req.tap_sel) <= FILTER_ORDER;
    assign hist_we  = req_acc && (req_kind == prr_pkg::REQ_SAMPLE);
    assign coef_we  = req_acc && (req_kind == prr_pkg::REQ_LOAD_COEF) && ph_ok && tap_ok;
    assign shift_we = req_acc && (req_kind == prr_pkg::REQ_LOAD_SHIFT) && ph_ok;

    assign coef_waddr = CW'(i_req.phase_sel) * CW'(TAPS) + CW'(i_req.tap_sel);
    assign coef_base  = CW'(r_phase) * CW'(TAPS);

    // Effective L and M: zero acts as one, L saturates at the phase count.
    always_comb begin
        priority if (r_interp == '0) begin
            l_eff = 4'd1;
        end else if (32'(r_interp) > MAX_PHASES) begin
            l_eff = 4'(MAX_PHASES);
        end else begin
            l_eff = 4'(r_interp);
        end
        m_eff = (r_decim == '0) ? prr_pkg::DECIM_W'(1) : r_decim;
    end

    assign cur_shift   = r_shift[r_phase];
    assign start_slot  = wrap_slot($signed({2'b00, r_base_slot}) + (SW + 2)'(cur_shift));
    assign wr_slot_inc = (r_wr_slot == SW'(HISTORY_DEPTH - 1)) ? '0 : r_wr_slot + SW'(1);
    assign rd_slot_inc = (r_rd_slot == SW'(HISTORY_DEPTH - 1)) ? '0 : r_rd_slot + SW'(1);

    // A window is complete when more than FILTER_ORDER elements lie past its
    // start; a start beyond the newest element (sign bit set) counts as not yet filled.
    assign ahead  = r_seen - r_start;
    assign win_ok = !ahead[31] && (ahead > 32'(FILTER_ORDER));
    assign more   = win_ok && (r_nres < NW'(prr_pkg::RESULT_CAP));

    // Advance to the next output: one position, plus M-L after the last phase.
    assign phase_inc     = 4'(r_phase) + 4'd1;
    assign ph_wrap       = phase_inc >= l_eff;
    assign delta         = ph_wrap ? (7'(m_eff) - 7'(l_eff) + 7'sd1) : 7'sd1;
    assign base_slot_nxt = wrap_slot($signed({2'b00, r_base_slot}) + (SW + 2)'(delta));

    assign out_free  = !r_out_valid || o_res.ready;
    assign pipe_idle = !r_s1 && !r_s2;
    assign mac_last  = r_tap == TW'(FILTER_ORDER);
    assign res_done  = (r_state == S_DRAIN) && pipe_idle;
    assign emit_load = (r_state == S_EMIT) && out_free;
    assign finish    = ((r_state == S_CHECK) && !r_pend_vld && !more)
                    || (emit_load && !r_more);

    assign h_re = r_hist_v ? $signed(r_hist_q[HW-1:prr_pkg::SAMPLE_W]) : '0;
    assign h_im = r_hist_v ? $signed(r_hist_q[prr_pkg::SAMPLE_W-1:0]) : '0;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    unique case (req_kind)
                        prr_pkg::REQ_SAMPLE:     n_state = S_ADDR;
                        prr_pkg::REQ_END:        n_state = S_PUSH;
                        prr_pkg::REQ_LOAD_COEF,
                        prr_pkg::REQ_LOAD_SHIFT: n_state = S_IDLE;
                    endcase
                end
            end
            S_PUSH: begin
                if (r_zcnt == ZW'(HALF - 1)) n_state = S_ADDR;
            end
            S_ADDR: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (r_pend_vld) begin
                    n_state = S_EMIT;
                end else if (more) begin
                    n_state = S_MAC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MAC: begin
                if (mac_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (pipe_idle) n_state = S_ADDR;
            end
            S_EMIT: begin
                if (out_free) n_state = r_more ? S_MAC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_interp    <= prr_pkg::INTERP_W'(1);
            r_decim     <= prr_pkg::DECIM_W'(1);
            r_hvalid    <= '0;
            r_seen      <= 32'(HALF);
            r_wr_slot   <= SW'(HALF);
            r_base      <= '0;
            r_base_slot <= '0;
            r_phase     <= '0;
            r_nres      <= '0;
            r_is_end    <= 1'b0;
            r_zcnt      <= '0;
            r_more      <= 1'b0;
            r_tap       <= '0;
            r_s1        <= 1'b0;
            r_s2        <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_idx == prr_pkg::CFG_INTERP) begin
                    r_interp <= i_cfg_data[prr_pkg::INTERP_W-1:0];
                end else if (i_cfg_idx == prr_pkg::CFG_DECIM) begin
                    r_decim <= i_cfg_data[prr_pkg::DECIM_W-1:0];
                end
            end

            // Start of a sample or end item
            if (hist_we) begin
                r_hvalid[r_wr_slot] <= 1'b1;
                r_seen              <= r_seen + 32'd1;
                r_wr_slot           <= wr_slot_inc;
                r_nres              <= '0;
                r_is_end            <= 1'b0;
            end
            if (req_acc && (req_kind == prr_pkg::REQ_END)) begin
                r_nres   <= '0;
                r_is_end <= 1'b1;
                r_zcnt   <= '0;
            end

            // Trailing zeros: an invalid slot reads as zero
            if (r_state == S_PUSH) begin
                r_hvalid[r_wr_slot] <= 1'b0;
                r_seen              <= r_seen + 32'd1;
                r_wr_slot           <= wr_slot_inc;
                r_zcnt              <= r_zcnt + ZW'(1);
            end

            if (r_state == S_CHECK) begin
                r_more <= more;
            end

            if (r_state == S_MAC) begin
                r_tap <= r_tap + TW'(1);
            end else begin
                r_tap <= '0;
            end
            r_s1 <= (r_state == S_MAC);
            r_s2 <= r_s1;

            // One result finished: hold it and advance to the next output
            if (res_done) begin
                r_pend_vld  <= 1'b1;
                r_nres      <= r_nres + NW'(1);
                r_phase     <= ph_wrap ? '0 : PW'(phase_inc);
                r_base      <= r_base + 32'(delta);
                r_base_slot <= base_slot_nxt;
            end

            if (emit_load) begin
                r_pend_vld  <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            // End of stream: rewind for a new stream, keep tables and L/M
            if (finish && r_is_end) begin
                r_hvalid    <= '0;
                r_seen      <= 32'(HALF);
                r_wr_slot   <= SW'(HALF);
                r_base      <= '0;
                r_base_slot <= '0;
                r_phase     <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_ADDR) begin
            r_start     <= r_base + 32'(cur_shift);
            r_rd_slot   <= start_slot;
            r_coef_addr <= coef_base;
        end else if (r_state == S_MAC) begin
            r_rd_slot   <= rd_slot_inc;
            r_coef_addr <= r_coef_addr + CW'(1);
        end

        if (shift_we) begin
            r_shift[PW'(i_req.phase_sel)] <= $signed(i_req.load_value[prr_pkg::SHIFT_W-1:0]);
        end

        r_prod_re <= PROD_W'(h_re) * PROD_W'(r_coef_q);
        r_prod_im <= PROD_W'(h_im) * PROD_W'(r_coef_q);

        if ((r_state == S_CHECK) || (r_state == S_EMIT)) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_s2) begin
            r_acc_re <= r_acc_re + AW'(r_prod_re);
            r_acc_im <= r_acc_im + AW'(r_prod_im);
        end

        if (res_done) begin
            r_pend_re <= round_sat(r_acc_re);
            r_pend_im <= round_sat(r_acc_im);
        end

        if (emit_load) begin
            r_out_re   <= r_pend_re;
            r_out_im   <= r_pend_im;
            r_out_last <= !r_more;
        end
    end

    // Sample history memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[r_wr_slot] <= {i_req.sample_re, i_req.sample_im};
        end
        r_hist_q <= r_hist_mem[r_rd_slot];
        r_hist_v <= r_hvalid[r_rd_slot];
    end

    // Coefficient memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[coef_waddr] <= i_req.load_value;
        end
        r_coef_q <= r_coef_mem[r_coef_addr];
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign i_req.ready  = (r_state == S_IDLE);
    assign o_res.valid  = r_out_valid;
    assign o_res.out_re = r_out_re;
    assign o_res.out_im = r_out_im;
    assign o_res.last   = r_out_last;

endmodule

@@ src/prr_checker.sv @@
// Port-level checks of the resampler top, attached by the bind at the end.
// Depends on prr_pkg and polyphase_rational_resampler_top.
`timescale 1ns / 1ps

module prr_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_req_valid,
    input logic                                i_req_ready,
    input logic [prr_pkg::REQ_W-1:0]           i_req_type,
    input logic                                i_res_valid,
    input logic                                i_res_ready,
    input logic signed [prr_pkg::SAMPLE_W-1:0] i_res_re,
    input logic signed [prr_pkg::SAMPLE_W-1:0] i_res_im,
    input logic                                i_res_last
);

    // A stalled result holds its payload
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_re) && $stable(i_res_im) && $stable(i_res_last)))
        else $error("result changed while stalled");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // Sample and end items hold ready low in the cycle after they are accepted
    a_item_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready &&
         (i_req_type == prr_pkg::REQ_SAMPLE || i_req_type == prr_pkg::REQ_END)) |=>
            !i_req_ready)
        else $error("ready right after a sample or end item");

    // A result that is not the last of its item means the item is still in work
    a_nonlast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_last) |-> !i_req_ready)
        else $error("idle while a non-final result is pending");

endmodule

bind polyphase_rational_resampler_top prr_checker u_prr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_type  (i_req.req_type),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_re    (o_res.out_re),
    .i_res_im    (o_res.out_im),
    .i_res_last  (o_res.last)
);
